@@ design/document_type_sniffer_top_macros.svh @@
// Assertion helpers used by the sniffer RTL.
`ifndef DOCUMENT_TYPE_SNIFFER_TOP_MACROS_SVH
`define DOCUMENT_TYPE_SNIFFER_TOP_MACROS_SVH

`define DTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dts_pkg.sv @@
package dts_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [2:0] doc_type;
    logic [3:0] encoding_code;
  } out_word_t;

  typedef enum logic [3:0] {
    J_OPEN, J_KEYQ, J_KEY, J_COLON, J_VALUE, J_PASS, J_FAIL
  } json_phase_t;

  typedef enum logic [2:0] {
    X_OPEN, X_AFTER_LT, X_HEADER, X_TAG, X_PASS, X_FAIL
  } xml_phase_t;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
  localparam logic [2:0] TYPE_JSON    = 3'd1;
  localparam logic [2:0] TYPE_XML     = 3'd2;
  localparam logic [2:0] TYPE_TSV     = 3'd3;
  localparam logic [2:0] TYPE_TEXT    = 3'd4;

  localparam logic [3:0] KW_FOUND  = 4'd9;
  localparam logic [3:0] KW_QUOTED = 4'd10;

  localparam logic [1:0] TSV_EQUAL   = 2'd2;
  localparam logic [1:0] TSV_UNEQUAL = 2'd3;

  function automatic logic [7:0] keyword_char(input logic [3:0] pos);
    case (pos)
      4'd0: keyword_char = "e";
      4'd1: keyword_char = "n";
      4'd2: keyword_char = "c";
      4'd3: keyword_char = "o";
      4'd4: keyword_char = "d";
      4'd5: keyword_char = "i";
      4'd6: keyword_char = "n";
      4'd7: keyword_char = "g";
      4'd8: keyword_char = "=";
      default: keyword_char = 8'd0;
    endcase
  endfunction

  function automatic logic [3:0] enc_len(input logic [2:0] k);
    case (k)
      3'd0: enc_len = 4'd5;
      3'd5: enc_len = 4'd6;
      3'd6: enc_len = 4'd6;
      3'd7: enc_len = 4'd10;
      default: enc_len = 4'd8;
    endcase
  endfunction

  // names padded with zeros; only positions below enc_len are compared
  function automatic logic [7:0] enc_char(input logic [2:0] k, input logic [3:0] pos);
    logic [79:0] s;
    s = '0;
    case (k)
      3'd0: s = {"utf-8", 40'd0};
      3'd1: s = {"utf-16be", 16'd0};
      3'd2: s = {"utf-16le", 16'd0};
      3'd3: s = {"utf-32be", 16'd0};
      3'd4: s = {"utf-32le", 16'd0};
      3'd5: s = {"utf-16", 32'd0};
      3'd6: s = {"utf-32", 32'd0};
      3'd7: s = "isolatin-1";
      default: s = '0;
    endcase
    if (pos < 4'd10) enc_char = s[8'(79 - 8 * pos) -: 8];
    else enc_char = 8'd0;
  endfunction

  function automatic logic is_value_start(input logic [7:0] b);
    case (b)
      "[", "]", "{", "}", "E", "-", "+", ".", "'", "\"",
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": is_value_start = 1'b1;
      default: is_value_start = 1'b0;
    endcase
  endfunction

endpackage

@@ design/document_type_sniffer_top.sv @@
// Document type sniffer.
// Input channel: one document byte per word with an is_last flag, valid/stall.
// Result channel: one word (doc_type, encoding_code) per document, sent after
// the word carrying is_last; valid/stall.
// Each byte updates the JSON, XML, TSV and text checkers; a new byte can be
// accepted every cycle while in_stall is low. The result appears in the output
// register in the cycle after the last byte is accepted.
// The output register holds its word while out_stall is high; the input keeps
// flowing as long as the output register is empty or is being drained, so
// in_stall only rises when a result is waiting and the receiver stalls.
// After the last byte all checker state returns to its reset value, ready for
// the next document with no gap.
// Synchronous active-low reset clears all checkers and the output valid.
// Priority of the reported type: json, xml, tsv, text, else unknown.
`include "document_type_sniffer_top_macros.svh"

module document_type_sniffer_top #(
  parameter int TEXT_SCAN_LEN = 1024,
  parameter int HEADER_MAX    = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dts_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dts_pkg::out_word_t out_data
);

  localparam int TIW = $clog2(TEXT_SCAN_LEN + 1);
  localparam int HLW = $clog2(HEADER_MAX + 1);

  dts_pkg::json_phase_t json_r, json_nxt;
  dts_pkg::xml_phase_t  xml_r, xml_nxt;
  logic [1:0]     lines_r, lines_nxt;
  logic [15:0]    tabs_cur_r, tabs_cur_nxt;
  logic [15:0]    tabs_first_r, tabs_first_nxt;
  logic           text_ok_r, text_ok_nxt;
  logic [TIW-1:0] text_idx_r, text_idx_nxt;
  logic [HLW-1:0] hdr_len_r, hdr_len_nxt;
  logic [3:0]     kw_r, kw_nxt;
  logic [7:0]     quote_r, quote_nxt;
  logic [7:0]     cand_r, cand_nxt;
  logic [3:0]     npos_r, npos_nxt;
  logic [3:0]     enc_r, enc_nxt;

  logic               out_valid_r;
  dts_pkg::out_word_t out_data_r, out_data_nxt;
  logic               take;
  logic [7:0]         b, c;
  logic               done;

  assign in_stall  = out_valid_r && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;
  assign c         = b | 8'h20;
  assign done      = take && in_data.is_last;

  always_comb begin
    json_nxt = json_r;
    xml_nxt = xml_r;
    lines_nxt = lines_r;
    tabs_cur_nxt = tabs_cur_r;
    tabs_first_nxt = tabs_first_r;
    text_ok_nxt = text_ok_r;
    text_idx_nxt = text_idx_r;
    hdr_len_nxt = hdr_len_r;
    kw_nxt = kw_r;
    quote_nxt = quote_r;
    cand_nxt = cand_r;
    npos_nxt = npos_r;
    enc_nxt = enc_r;

    case (json_r)
      dts_pkg::J_OPEN: json_nxt = (b == "{") ? dts_pkg::J_KEYQ : dts_pkg::J_FAIL;
      dts_pkg::J_KEYQ:
        if (b > 8'd32) json_nxt = (b == "\"") ? dts_pkg::J_KEY : dts_pkg::J_FAIL;
      dts_pkg::J_KEY: if (b == "\"") json_nxt = dts_pkg::J_COLON;
      dts_pkg::J_COLON:
        if (b > 8'd32) json_nxt = (b == ":") ? dts_pkg::J_VALUE : dts_pkg::J_FAIL;
      dts_pkg::J_VALUE:
        if (b > 8'd32)
          json_nxt = dts_pkg::is_value_start(b) ? dts_pkg::J_PASS : dts_pkg::J_FAIL;
      dts_pkg::J_PASS: json_nxt = dts_pkg::J_PASS;
      default: json_nxt = dts_pkg::J_FAIL;
    endcase

    if (b != 8'd0) begin
      case (xml_r)
        dts_pkg::X_OPEN: xml_nxt = (b == "<") ? dts_pkg::X_AFTER_LT : dts_pkg::X_FAIL;
        dts_pkg::X_AFTER_LT: xml_nxt = (b == "?") ? dts_pkg::X_HEADER : dts_pkg::X_TAG;
        dts_pkg::X_HEADER: begin
          if (b == "<") begin
            xml_nxt = dts_pkg::X_FAIL;
          end else if (b == ">") begin
            xml_nxt = (kw_r == dts_pkg::KW_FOUND) ? dts_pkg::X_FAIL : dts_pkg::X_PASS;
          end else if (b > 8'd32) begin
            if ({1'b0, hdr_len_r} + 1'b1 >= (HLW+1)'(HEADER_MAX)) begin
              xml_nxt = dts_pkg::X_FAIL;
            end else begin
              hdr_len_nxt = hdr_len_r + 1'b1;
              if (kw_r < dts_pkg::KW_FOUND) begin
                if (c == dts_pkg::keyword_char(kw_r)) kw_nxt = kw_r + 4'd1;
                else kw_nxt = (c == "e") ? 4'd1 : 4'd0;
              end else if (kw_r == dts_pkg::KW_FOUND) begin
                if (c == "\"" || c == "'") begin
                  quote_nxt = c;
                  kw_nxt = dts_pkg::KW_QUOTED;
                  cand_nxt = 8'hFF;
                  npos_nxt = 4'd0;
                end else begin
                  xml_nxt = dts_pkg::X_FAIL;
                end
              end else if (enc_r == 4'd0 && cand_r != 8'd0) begin
                for (int k = 0; k < 8; k++) begin
                  if (cand_r[k]) begin
                    if (npos_r < dts_pkg::enc_len(3'(k))) begin
                      if (dts_pkg::enc_char(3'(k), npos_r) != c) cand_nxt[k] = 1'b0;
                    end else if (npos_r == dts_pkg::enc_len(3'(k)) && c == quote_r) begin
                      enc_nxt = 4'(k + 1);
                    end else begin
                      cand_nxt[k] = 1'b0;
                    end
                  end
                end
                if (npos_r < 4'd15) npos_nxt = npos_r + 4'd1;
              end
            end
          end
        end
        dts_pkg::X_TAG:
          if (b == "<") xml_nxt = dts_pkg::X_FAIL;
          else if (b == ">") xml_nxt = dts_pkg::X_PASS;
        dts_pkg::X_PASS: xml_nxt = dts_pkg::X_PASS;
        default: xml_nxt = dts_pkg::X_FAIL;
      endcase
    end

    if (lines_r < 2'd2) begin
      if (b == 8'h0A) begin
        if (lines_r == 2'd0) begin
          tabs_first_nxt = tabs_cur_r;
          lines_nxt = 2'd1;
        end else begin
          lines_nxt = (tabs_first_r == tabs_cur_r) ? dts_pkg::TSV_EQUAL
                                                   : dts_pkg::TSV_UNEQUAL;
        end
        tabs_cur_nxt = 16'd0;
      end else if (b == 8'h09 && tabs_cur_r != 16'hFFFF) begin
        tabs_cur_nxt = tabs_cur_r + 16'd1;
      end
    end

    if (text_idx_r < TIW'(TEXT_SCAN_LEN)) begin
      text_idx_nxt = text_idx_r + 1'b1;
      if (b != 8'd0 && b < 8'd32 && b != 8'h09 && b != 8'h0A && b != 8'h0D)
        text_ok_nxt = 1'b0;
    end

    out_data_nxt.encoding_code = 4'd0;
    if (json_nxt == dts_pkg::J_PASS) begin
      out_data_nxt.doc_type = dts_pkg::TYPE_JSON;
    end else if (xml_nxt == dts_pkg::X_PASS) begin
      out_data_nxt.doc_type = dts_pkg::TYPE_XML;
      out_data_nxt.encoding_code = enc_nxt;
    end else if (lines_nxt == dts_pkg::TSV_EQUAL) begin
      out_data_nxt.doc_type = dts_pkg::TYPE_TSV;
    end else if (text_ok_nxt) begin
      out_data_nxt.doc_type = dts_pkg::TYPE_TEXT;
    end else begin
      out_data_nxt.doc_type = dts_pkg::TYPE_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || done) begin
      json_r <= dts_pkg::J_OPEN;
      xml_r <= dts_pkg::X_OPEN;
      lines_r <= 2'd0;
      tabs_cur_r <= 16'd0;
      tabs_first_r <= 16'd0;
      text_ok_r <= 1'b1;
      text_idx_r <= '0;
      hdr_len_r <= '0;
      kw_r <= 4'd0;
      quote_r <= 8'd0;
      cand_r <= 8'hFF;
      npos_r <= 4'd0;
      enc_r <= 4'd0;
    end else if (take) begin
      json_r <= json_nxt;
      xml_r <= xml_nxt;
      lines_r <= lines_nxt;
      tabs_cur_r <= tabs_cur_nxt;
      tabs_first_r <= tabs_first_nxt;
      text_ok_r <= text_ok_nxt;
      text_idx_r <= text_idx_nxt;
      hdr_len_r <= hdr_len_nxt;
      kw_r <= kw_nxt;
      quote_r <= quote_nxt;
      cand_r <= cand_nxt;
      npos_r <= npos_nxt;
      enc_r <= enc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  `DTS_ASSERT_NEXT(a_result_after_last, clk, rst_n, done, out_valid_r, "no result after last word")
  `DTS_ASSERT_IMPL(a_enc_only_xml, clk, rst_n, out_valid_r && out_data_r.doc_type != dts_pkg::TYPE_XML, out_data_r.encoding_code == 4'd0, "encoding on non-xml result")
  `DTS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, done, json_r == dts_pkg::J_OPEN && xml_r == dts_pkg::X_OPEN && text_idx_r == '0, "state not cleared")
  `DTS_ASSERT_IMPL(a_stall_only_full, clk, rst_n, in_stall, out_valid_r, "input stalled with empty output")

endmodule
